>>> rtl/bbc_pkg.sv
// ---------------------------------------------------------------------------
// bbc_pkg
// Shared types, constants and bracket decode for the bracket balance checker
// ---------------------------------------------------------------------------
package bbc_pkg;

    localparam int STACK_DEPTH_DEF = 32;

    typedef enum logic [1:0] {
        KIND_PAREN  = 2'd0,
        KIND_BRACE  = 2'd1,
        KIND_SQUARE = 2'd2,
        KIND_NONE   = 2'd3
    } t_kind;

    localparam logic [7:0] CH_LPAREN  = 8'h28;
    localparam logic [7:0] CH_RPAREN  = 8'h29;
    localparam logic [7:0] CH_LBRACE  = 8'h7B;
    localparam logic [7:0] CH_RBRACE  = 8'h7D;
    localparam logic [7:0] CH_LSQUARE = 8'h5B;
    localparam logic [7:0] CH_RSQUARE = 8'h5D;

    function automatic t_kind opening_kind(input logic [7:0] c);
        t_kind k;
        case (c)
            CH_LPAREN:  k = KIND_PAREN;
            CH_LBRACE:  k = KIND_BRACE;
            CH_LSQUARE: k = KIND_SQUARE;
            default:    k = KIND_NONE;
        endcase
        return k;
    endfunction

    function automatic t_kind closing_kind(input logic [7:0] c);
        t_kind k;
        case (c)
            CH_RPAREN:  k = KIND_PAREN;
            CH_RBRACE:  k = KIND_BRACE;
            CH_RSQUARE: k = KIND_SQUARE;
            default:    k = KIND_NONE;
        endcase
        return k;
    endfunction

endpackage

>>> rtl/bbc_if.sv
// ---------------------------------------------------------------------------
// bbc_sym_if / bbc_res_if
// Valid/ready channels for input characters and expression results
// ---------------------------------------------------------------------------
interface bbc_sym_if;
    logic       valid;
    logic       ready;
    logic [7:0] symbol;
    logic       last_symbol;

    modport source (output valid, output symbol, output last_symbol, input ready);
    modport sink   (input valid, input symbol, input last_symbol, output ready);
endinterface

interface bbc_res_if;
    logic valid;
    logic ready;
    logic expression_valid;

    modport source (output valid, output expression_valid, input ready);
    modport sink   (input valid, input expression_valid, output ready);
endinterface

>>> rtl/bbc_stack_mem.sv
// ---------------------------------------------------------------------------
// bbc_stack_mem
// Bracket stack storage: one write port, one registered read port
// ---------------------------------------------------------------------------
module bbc_stack_mem #(
    parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF,
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1
) (
    input  logic               i_clk,
    input  logic               i_we,
    input  logic [AW-1:0]      i_waddr,
    input  bbc_pkg::t_kind     i_wdata,
    input  logic [AW-1:0]      i_raddr,
    output bbc_pkg::t_kind     o_rdata
);

    bbc_pkg::t_kind r_mem [STACK_DEPTH];
    bbc_pkg::t_kind r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

>>> rtl/bbc_out_stage.sv
// ---------------------------------------------------------------------------
// bbc_out_stage
// Output register for result words, decoupling the result channel
// ---------------------------------------------------------------------------
module bbc_out_stage (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_load,
    input  logic              i_value,
    output logic              o_room,
    bbc_res_if.source         o_res
);

    logic r_valid;
    logic n_valid;
    logic r_value;

    // room when empty or the held word leaves this cycle
    assign o_room = !r_valid || o_res.ready;

    always_comb begin
        n_valid = r_valid;
        if (o_res.ready) begin
            n_valid = 1'b0;
        end
        if (i_load) begin
            n_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_value <= i_value;
        end
    end

    assign o_res.valid            = r_valid;
    assign o_res.expression_valid = r_value;

endmodule

>>> rtl/bracket_balance_checker.sv
// ---------------------------------------------------------------------------
// bracket_balance_checker
// Checks an expression, one character per word, for balanced brackets
// ---------------------------------------------------------------------------
// Takes one character per clock cycle and keeps that rate indefinitely, as
// long as the result channel drains. Each ( { [ pushes its kind, each ) } ]
// pops and must match; any other character, a pop of an empty stack or a push
// onto a full stack marks the expression invalid. The word flagged as last
// yields one result word, registered, in the cycle after it is accepted, and
// the stack starts empty for the next expression. The top of the stack is
// held in a register and the stack body in a one-write, one-read memory; the
// entry below the top is read every cycle so that pops can follow each other
// without a gap. No clearing pass is needed after reset.
module bracket_balance_checker #(
    parameter int STACK_DEPTH = bbc_pkg::STACK_DEPTH_DEF,
    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1,
    localparam int CW = $clog2(STACK_DEPTH + 1)
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    bbc_sym_if.sink    i_sym,
    bbc_res_if.source  o_res
);

    logic            r_err;
    logic            n_err;
    logic [CW-1:0]   r_count;
    logic [CW-1:0]   n_count;
    bbc_pkg::t_kind  r_top;
    bbc_pkg::t_kind  n_top;

    logic            room;
    logic            acc;
    bbc_pkg::t_kind  open_k;
    bbc_pkg::t_kind  close_k;
    logic            mem_we;
    logic [AW-1:0]   mem_waddr;
    logic [AW-1:0]   mem_raddr;
    logic [CW-1:0]   below_idx;
    bbc_pkg::t_kind  below_top;
    logic            res_load;
    logic            res_value;

    assign i_sym.ready = room;
    assign acc         = i_sym.valid && room;
    assign open_k      = bbc_pkg::opening_kind(i_sym.symbol);
    assign close_k     = bbc_pkg::closing_kind(i_sym.symbol);

    always_comb begin
        n_err     = r_err;
        n_count   = r_count;
        n_top     = r_top;
        mem_we    = 1'b0;
        mem_waddr = r_count[AW-1:0];
        res_load  = 1'b0;
        res_value = 1'b0;
        if (acc && !r_err) begin
            if (open_k != bbc_pkg::KIND_NONE) begin
                if (r_count == CW'(STACK_DEPTH)) begin
                    n_err = 1'b1;
                end else begin
                    mem_we  = 1'b1;
                    n_top   = open_k;
                    n_count = r_count + CW'(1);
                end
            end else if (close_k != bbc_pkg::KIND_NONE) begin
                if (r_count == '0) begin
                    n_err = 1'b1;
                end else begin
                    n_count = r_count - CW'(1);
                    n_top   = below_top;
                    if (r_top != close_k) begin
                        n_err = 1'b1;
                    end
                end
            end else begin
                n_err = 1'b1;
            end
        end
        if (acc && i_sym.last_symbol) begin
            res_load  = 1'b1;
            res_value = !n_err && (n_count == '0);
            n_err     = 1'b0;
            n_count   = '0;
        end
    end

    // prefetch the entry just below the next top
    assign below_idx = n_count - CW'(2);
    assign mem_raddr = below_idx[AW-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_err   <= 1'b0;
            r_count <= '0;
        end else begin
            r_err   <= n_err;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_top <= n_top;
    end

    bbc_stack_mem #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_stack_mem (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (open_k),
        .i_raddr (mem_raddr),
        .o_rdata (below_top)
    );

    bbc_out_stage u_out_stage (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (res_load),
        .i_value (res_value),
        .o_room  (room),
        .o_res   (o_res)
    );

endmodule

>>> tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// Self-checking regression for the bracket balance checker
// ---------------------------------------------------------------------------
// Characters go in one word at a time, and the last word of each expression
// is flagged. A scoreboard keeps its own bracket stack and predicts the
// verdict of each expression from the accepted words. It compares every
// result word with the oldest verdict still outstanding. The run starts with
// a short hand-written set: each bracket kind, mismatches, pops of an empty
// stack, stray characters and the extreme byte values. After that come random
// expressions. Most are well nested with random kinds. Some nest to the full
// stack depth and one past it. Others are broken nestings or random noise.
// Both sides idle at random. The result side is also held off for a long
// stretch, so that the block backs up. The sender also pauses now and then
// until every result is in.
// ---------------------------------------------------------------------------
module tb_top;

    localparam int CLK_PERIOD   = 8;
    localparam int DEPTH        = bbc_pkg::STACK_DEPTH_DEF;
    localparam int WORD_TARGET  = 1275;
    localparam int HOLD_CYCLES  = 300;
    localparam int LIMIT_CYCLES = 400000;

    localparam logic [7:0] OPEN_CH  [3] = '{bbc_pkg::CH_LPAREN, bbc_pkg::CH_LBRACE,
                                            bbc_pkg::CH_LSQUARE};
    localparam logic [7:0] CLOSE_CH [3] = '{bbc_pkg::CH_RPAREN, bbc_pkg::CH_RBRACE,
                                            bbc_pkg::CH_RSQUARE};

    // predicts one verdict per expression and checks the result words
    class balance_scoreboard;
        bbc_pkg::t_kind kinds [DEPTH];
        int unsigned    depth;
        bit             err;
        bit             verdicts_due [$];
        int             failures;
        int             expressions;
        int             results_seen;
        int             valid_seen;

        function new();
            depth = 0;
            err = 0;
            failures = 0;
            expressions = 0;
            results_seen = 0;
            valid_seen = 0;
        endfunction

        function void note_word(input logic [7:0] sym, input logic last);
            bit             is_open;
            bit             is_close;
            bbc_pkg::t_kind k;
            is_open = 1'b0;
            is_close = 1'b0;
            k = bbc_pkg::KIND_NONE;
            case (sym)
                bbc_pkg::CH_LPAREN:  begin is_open = 1'b1;  k = bbc_pkg::KIND_PAREN;  end
                bbc_pkg::CH_LBRACE:  begin is_open = 1'b1;  k = bbc_pkg::KIND_BRACE;  end
                bbc_pkg::CH_LSQUARE: begin is_open = 1'b1;  k = bbc_pkg::KIND_SQUARE; end
                bbc_pkg::CH_RPAREN:  begin is_close = 1'b1; k = bbc_pkg::KIND_PAREN;  end
                bbc_pkg::CH_RBRACE:  begin is_close = 1'b1; k = bbc_pkg::KIND_BRACE;  end
                bbc_pkg::CH_RSQUARE: begin is_close = 1'b1; k = bbc_pkg::KIND_SQUARE; end
                default:             k = bbc_pkg::KIND_NONE;
            endcase
            // once in error the rest of the expression is ignored
            if (!err) begin
                if (is_open) begin
                    if (depth >= DEPTH) begin
                        err = 1'b1;
                    end else begin
                        kinds[depth] = k;
                        depth++;
                    end
                end else if (is_close) begin
                    if (depth == 0) begin
                        err = 1'b1;
                    end else begin
                        depth--;
                        if (kinds[depth] != k) err = 1'b1;
                    end
                end else begin
                    err = 1'b1;
                end
            end
            if (last) begin
                verdicts_due.push_back(!err && depth == 0);
                depth = 0;
                err = 1'b0;
                expressions++;
            end
        endfunction

        function void check_result(input logic actual);
            bit want;
            results_seen++;
            if (actual === 1'b1) valid_seen++;
            if (verdicts_due.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("ERROR: result word %0d (%b) with no expression outstanding",
                             results_seen, actual);
            end else begin
                want = verdicts_due.pop_front();
                if (actual !== want) begin
                    failures++;
                    if (failures <= 10)
                        $display("ERROR: result word %0d: expected valid=%b, got %b",
                                 results_seen, want, actual);
                end
            end
        endfunction

        function int pending();
            return verdicts_due.size();
        endfunction
    endclass

    logic clk;
    logic rst_n;
    bit   sender_quiet;
    bit   recv_quiet;
    int   holds_asked = 0;
    int   holds_done = 0;
    int   words_sent;

    balance_scoreboard sb;

    bbc_sym_if sym_if ();
    bbc_res_if res_if ();

    bracket_balance_checker DUT (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_sym   (sym_if),
        .o_res   (res_if)
    );

    initial clk = 1'b0;
    always #(CLK_PERIOD / 2) clk = ~clk;

    initial begin
        #(LIMIT_CYCLES * CLK_PERIOD);
        $display("timeout with %0d results still outstanding", sb.pending());
        $display("bracket_balance_checker regression: fail");
        $finish;
    end

    // result side: random stalls, and a long hold-off on request
    initial begin
        int stall;
        res_if.ready = 1'b0;
        wait (rst_n === 1'b1);
        forever begin
            @(negedge clk);
            if (holds_done < holds_asked) begin
                res_if.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                holds_done++;
            end
            stall = recv_quiet ? 0 : $urandom_range(0, 3);
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(negedge clk);
            end
            res_if.ready <= 1'b1;
            do @(posedge clk);
            while (!(res_if.valid && res_if.ready) && holds_done >= holds_asked);
        end
    end

    always @(posedge clk) begin
        if (rst_n && res_if.valid && res_if.ready) sb.check_result(res_if.expression_valid);
    end

    task automatic send_word(input logic [7:0] sym, input logic last);
        int gap;
        gap = sender_quiet ? 0 : $urandom_range(0, 3);
        if (gap > 0) begin
            @(negedge clk);
            sym_if.valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        sym_if.valid       <= 1'b1;
        sym_if.symbol      <= sym;
        sym_if.last_symbol <= last;
        do @(posedge clk); while (!sym_if.ready);
        sb.note_word(sym, last);
        words_sent++;
    endtask

    task automatic send_text(input string txt);
        int i;
        for (i = 0; i < txt.len(); i++) send_word(txt[i], i == txt.len() - 1);
    endtask

    // idle the input until every verdict is back, then let the block settle
    task automatic wait_for_results();
        @(negedge clk);
        sym_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (3) @(posedge clk);
    endtask

    // nested expression of random kinds; bias is the chance in percent of
    // opening rather than closing while both are allowed
    task automatic send_nested(input int pairs, input int max_depth, input int bias,
                               input bit broken);
        logic [7:0] seq [$];
        int         open_kinds [$];
        int         opens_left;
        int         k;
        int         pos;
        int         i;
        opens_left = pairs;
        while (opens_left > 0 || open_kinds.size() > 0) begin
            if (opens_left > 0 && (open_kinds.size() == 0 ||
                (open_kinds.size() < max_depth && $urandom_range(0, 99) < bias))) begin
                k = $urandom_range(0, 2);
                seq.push_back(OPEN_CH[k]);
                open_kinds.push_back(k);
                opens_left--;
            end else begin
                k = open_kinds.pop_back();
                seq.push_back(CLOSE_CH[k]);
            end
        end
        if (broken) begin
            pos = $urandom_range(0, seq.size() - 1);
            case ($urandom_range(0, 3))
                0: seq[pos] = 8'($urandom_range(0, 255));
                1: seq[pos] = CLOSE_CH[$urandom_range(0, 2)];
                2: if (seq.size() > 1) seq.delete(pos);
                default: seq.insert(pos, OPEN_CH[$urandom_range(0, 2)]);
            endcase
        end
        for (i = 0; i < seq.size(); i++) send_word(seq[i], i == seq.size() - 1);
    endtask

    task automatic send_noise();
        int len;
        int i;
        len = $urandom_range(1, 6);
        for (i = 0; i < len; i++) begin
            if ($urandom_range(0, 1))
                send_word(8'($urandom_range(0, 255)), i == len - 1);
            else if ($urandom_range(0, 1))
                send_word(OPEN_CH[$urandom_range(0, 2)], i == len - 1);
            else
                send_word(CLOSE_CH[$urandom_range(0, 2)], i == len - 1);
        end
    endtask

    // many short expressions while the result side is held off
    task automatic flood_during_hold();
        bit was_quiet;
        was_quiet = sender_quiet;
        sender_quiet = 1'b1;
        holds_asked++;
        repeat (48) begin
            if ($urandom_range(0, 1)) send_word(8'($urandom_range(0, 255)), 1'b1);
            else send_nested(1, 1, 100, 1'b0);
        end
        sender_quiet = was_quiet;
    endtask

    initial begin
        int expr_idx;
        int pick;
        sb = new();
        sender_quiet = 1'b0;
        recv_quiet = 1'b0;
        words_sent = 0;
        rst_n = 1'b0;
        sym_if.valid = 1'b0;
        sym_if.symbol = 8'h00;
        sym_if.last_symbol = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        send_text("()");
        send_text("{[()]}");
        send_text("(]");
        send_text(")");
        send_text(")(");
        send_text("a");
        send_text("([)]");
        send_text("((");
        send_text("x()");
        send_word(8'h00, 1'b1);
        send_word(8'hFF, 1'b1);
        wait_for_results();

        expr_idx = 0;
        while (words_sent < WORD_TARGET) begin
            if (expr_idx % 60 == 0) begin
                sender_quiet = ($urandom_range(0, 3) == 0);
                recv_quiet = ($urandom_range(0, 3) == 0);
            end
            if (expr_idx == 150 || expr_idx == 420) flood_during_hold();
            if (expr_idx % 100 == 99) wait_for_results();

            if (expr_idx == 0) begin
                send_nested(DEPTH, DEPTH, 100, 1'b0);          // stack exactly full
            end else if (expr_idx == 1) begin
                send_nested(DEPTH + 1, DEPTH + 1, 100, 1'b0);  // one push too many
            end else if ($urandom_range(0, 39) == 0) begin
                pick = $urandom_range(DEPTH - 2, DEPTH + 2);
                send_nested(pick, pick, 85, $urandom_range(0, 3) == 0);
            end else begin
                pick = $urandom_range(0, 9);
                if (pick < 6)
                    send_nested($urandom_range(1, 6), $urandom_range(1, 8), 50, 1'b0);
                else if (pick < 8)
                    send_nested($urandom_range(1, 6), $urandom_range(1, 8), 50, 1'b1);
                else
                    send_noise();
            end
            expr_idx++;
        end

        @(negedge clk);
        sym_if.valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (8) @(posedge clk);

        $display("covered %0d expressions in %0d words, %0d judged balanced",
                 sb.expressions, words_sent, sb.valid_seen);
        $display("%0d results checked, %0d long result hold-offs, %0d mismatches",
                 sb.results_seen, holds_done, sb.failures);
        if (sb.failures == 0 && sb.pending() == 0) begin
            $display("bracket_balance_checker regression: pass");
        end else begin
            $display("bracket_balance_checker regression: fail");
        end
        $finish;
    end

endmodule

>>> filelist.f
rtl/bbc_pkg.sv
rtl/bbc_if.sv
rtl/bbc_stack_mem.sv
rtl/bbc_out_stage.sv
rtl/bracket_balance_checker.sv
tb/sv/tb_top.sv
